// ===== rtl/task_slot_round_robin_scheduler_unit_macros.svh =====
// Assertion macros used by the scheduler top level.
`ifndef TASK_SLOT_ROUND_ROBIN_SCHEDULER_UNIT_MACROS_SVH
`define TASK_SLOT_ROUND_ROBIN_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSRR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tsrr_pkg.sv =====
// Types and constants of the task slot round-robin scheduler.
package tsrr_pkg;

	localparam int unsigned ID_W   = 31;
	localparam int unsigned CHAN_W = 64;

	localparam logic [ID_W-1:0] ID_MAX   = {ID_W{1'b1}};
	localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);

	typedef enum logic [1:0] {
		SLOT_UNUSED   = 2'd0,
		SLOT_RUNNABLE = 2'd1,
		SLOT_WAITING  = 2'd2
	} slot_state_t;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_SLEEP = 2'd1,
		OP_WAKE  = 2'd2,
		OP_SCHED = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_NO_SLOT = 2'd1,
		STAT_NO_RUN  = 2'd2
	} status_t;

	typedef struct packed {
		slot_state_t       state;
		logic [CHAN_W-1:0] chan;
		logic [ID_W-1:0]   id;
	} slot_t;

endpackage

// ===== rtl/tsrr_if.sv =====
// Request and response channel interfaces of the scheduler.
interface tsrr_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [63:0] channel;

	modport source (output valid, output mode, output channel, input ready);
	modport sink (input valid, input mode, input channel, output ready);
endinterface

interface tsrr_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [5:0]  slot;
	logic [30:0] task_id;
	logic [6:0]  woken_count;

	modport source (output valid, output status, output slot, output task_id,
		output woken_count, input ready);
	modport sink (input valid, input status, input slot, input task_id,
		input woken_count, output ready);
endinterface

// ===== rtl/tsrr_cell.sv =====
// One task slot of the rotating slot ring.
module tsrr_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  tsrr_pkg::slot_t nxt,
	output tsrr_pkg::slot_t cur
);
	import tsrr_pkg::*;

	slot_state_t       state_q;
	logic [CHAN_W-1:0] chan_q;
	logic [ID_W-1:0]   id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SLOT_UNUSED;
		end else if (shift) begin
			state_q <= nxt.state;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			chan_q <= nxt.chan;
			id_q   <= nxt.id;
		end
	end

	assign cur.state = state_q;
	assign cur.chan  = chan_q;
	assign cur.id    = id_q;

endmodule

// ===== rtl/task_slot_round_robin_scheduler_unit.sv =====
// Top level: slot ring of cells plus the head controller that walks it.
//
//  channel | dir | payload                              | transfer when
//  --------+-----+--------------------------------------+-----------------------
//  req     | in  | mode, channel                        | req.valid & req.ready
//  rsp     | out | status, slot, task_id, woken_count   | rsp.valid & rsp.ready
//
// Each item is taken in the idle state, then the ring rotates once per slot,
// all slots passing the head cell once in slot order.
// Reset empties every slot, sets the next id to 1 and the current slot to 0.
// The rotation holds on its last slot while a previous response is not taken;
// a new request is taken whenever the ring is at rest.
`include "task_slot_round_robin_scheduler_unit_macros.svh"

module task_slot_round_robin_scheduler_unit #(
	parameter int unsigned SLOT_COUNT = 64
) (
	input logic        clk,
	input logic        arst_n,
	tsrr_req_if.sink   req,
	tsrr_rsp_if.source rsp
);
	import tsrr_pkg::*;

	localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
	localparam int unsigned EXT_W = (IDX_W > 6) ? IDX_W : 6;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} fsm_t;

	fsm_t              state_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  cur_q;
	logic [ID_W-1:0]   next_id_q;
	op_t               op_q;
	logic [CHAN_W-1:0] chan_q;

	// walk accumulators
	logic              found_q, found_n;
	logic [IDX_W-1:0]  aslot_q, aslot_n;
	logic [ID_W-1:0]   aid_q, aid_n;
	logic [ID_W-1:0]   nid_n;
	logic              aft_q, aft_n;
	logic [IDX_W-1:0]  aft_slot_q, aft_slot_n;
	logic [ID_W-1:0]   aft_id_q, aft_id_n;
	logic              upto_q, upto_n;
	logic [IDX_W-1:0]  upto_slot_q, upto_slot_n;
	logic [ID_W-1:0]   upto_id_q, upto_id_n;
	logic [6:0]        woken_q, woken_n;

	// response register
	logic              rsp_valid_q;
	status_t           rsp_status_q;
	logic [5:0]        rsp_slot_q;
	logic [ID_W-1:0]   rsp_id_q;
	logic [6:0]        rsp_woken_q;

	slot_t             ring [SLOT_COUNT];
	slot_t             head_new;

	logic              take, last, out_free, shift, finish;

	assign take     = req.valid && req.ready;
	assign last     = (idx_q == IDX_LAST);
	assign out_free = !rsp_valid_q || rsp.ready;
	assign shift    = (state_q == ST_WALK) && (!last || out_free);
	assign finish   = (state_q == ST_WALK) && last && out_free;

	genvar g;
	generate
		for (g = 0; g < SLOT_COUNT; g++) begin : g_ring
			slot_t nxt;
			if (g == SLOT_COUNT - 1) begin : g_tail
				assign nxt = head_new;
			end else begin : g_mid
				assign nxt = ring[g+1];
			end
			tsrr_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.nxt    (nxt),
				.cur    (ring[g])
			);
		end
	endgenerate

	// Head logic: update the slot at the head and fold it into the accumulators.
	always_comb begin
		head_new    = ring[0];
		found_n     = found_q;
		aslot_n     = aslot_q;
		aid_n       = aid_q;
		nid_n       = next_id_q;
		aft_n       = aft_q;
		aft_slot_n  = aft_slot_q;
		aft_id_n    = aft_id_q;
		upto_n      = upto_q;
		upto_slot_n = upto_slot_q;
		upto_id_n   = upto_id_q;
		woken_n     = woken_q;
		case (op_q)
			OP_ALLOC: begin
				if (!found_q && ring[0].state == SLOT_UNUSED) begin
					head_new.state = SLOT_RUNNABLE;
					head_new.id    = next_id_q;
					found_n        = 1'b1;
					aslot_n        = idx_q;
					aid_n          = next_id_q;
					nid_n          = (next_id_q == ID_MAX) ? ID_FIRST : next_id_q + 1'b1;
				end
			end
			OP_WAKE: begin
				if (ring[0].state == SLOT_WAITING && ring[0].chan == chan_q) begin
					head_new.state = SLOT_RUNNABLE;
					woken_n        = woken_q + 1'b1;
				end
			end
			OP_SLEEP, OP_SCHED: begin
				if (op_q == OP_SLEEP && idx_q == cur_q) begin
					head_new.state = SLOT_WAITING;
					head_new.chan  = chan_q;
				end
				if (head_new.state == SLOT_RUNNABLE) begin
					if (idx_q > cur_q) begin
						if (!aft_q) begin
							aft_n      = 1'b1;
							aft_slot_n = idx_q;
							aft_id_n   = ring[0].id;
						end
					end else if (!upto_q) begin
						upto_n      = 1'b1;
						upto_slot_n = idx_q;
						upto_id_n   = ring[0].id;
					end
				end
			end
			default: ;
		endcase
	end

	// Response of the finished walk.
	status_t          res_status;
	logic [IDX_W-1:0] res_idx;
	logic [ID_W-1:0]  res_id;
	logic [6:0]       res_woken;
	logic [IDX_W-1:0] new_cur;
	logic [EXT_W-1:0] res_ext;

	always_comb begin
		res_status = STAT_OK;
		res_idx    = '0;
		res_id     = '0;
		res_woken  = '0;
		new_cur    = cur_q;
		case (op_q)
			OP_ALLOC: begin
				if (found_n) begin
					res_idx = aslot_n;
					res_id  = aid_n;
				end else begin
					res_status = STAT_NO_SLOT;
				end
			end
			OP_WAKE: begin
				res_woken = woken_n;
			end
			OP_SLEEP, OP_SCHED: begin
				if (aft_n) begin
					res_idx = aft_slot_n;
					res_id  = aft_id_n;
					new_cur = aft_slot_n;
				end else if (upto_n) begin
					res_idx = upto_slot_n;
					res_id  = upto_id_n;
					new_cur = upto_slot_n;
				end else begin
					res_status = STAT_NO_RUN;
					res_idx    = cur_q;
				end
			end
			default: ;
		endcase
		res_ext = EXT_W'(res_idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			cur_q       <= '0;
			next_id_q   <= ID_FIRST;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_WALK;
						idx_q   <= '0;
					end
				end
				ST_WALK: begin
					if (shift) begin
						next_id_q <= nid_n;
						if (last) begin
							state_q <= ST_IDLE;
							idx_q   <= '0;
							cur_q   <= new_cur;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: clear accumulators on transfer, advance on each rotation.
	always_ff @(posedge clk) begin
		if (take) begin
			op_q    <= op_t'(req.mode);
			chan_q  <= req.channel;
			found_q <= 1'b0;
			aft_q   <= 1'b0;
			upto_q  <= 1'b0;
			woken_q <= '0;
		end else if (shift) begin
			found_q <= found_n;
			aft_q   <= aft_n;
			upto_q  <= upto_n;
			woken_q <= woken_n;
		end
		if (shift) begin
			aslot_q     <= aslot_n;
			aid_q       <= aid_n;
			aft_slot_q  <= aft_slot_n;
			aft_id_q    <= aft_id_n;
			upto_slot_q <= upto_slot_n;
			upto_id_q   <= upto_id_n;
		end
		if (finish) begin
			rsp_status_q <= res_status;
			rsp_slot_q   <= res_ext[5:0];
			rsp_id_q     <= res_id;
			rsp_woken_q  <= res_woken;
		end
	end

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.slot        = rsp_slot_q;
	assign rsp.task_id     = rsp_id_q;
	assign rsp.woken_count = rsp_woken_q;

	`TSRR_ASSERT_NEXT(a_take_starts_walk, clk, arst_n, take, state_q == ST_WALK && idx_q == '0, "request transfer did not start a walk at slot zero")
	`TSRR_ASSERT_NEXT(a_walk_advances, clk, arst_n, state_q == ST_WALK && !last, state_q == ST_WALK && idx_q == IDX_W'($past(idx_q) + 1'b1), "walk did not advance by one slot")
	`TSRR_ASSERT_NOW(a_fail_payload, clk, arst_n, rsp.valid && rsp.status != STAT_OK, rsp.task_id == '0 && rsp.woken_count == '0, "failed response carries an id or a wake count")

endmodule
